FILE: rtl/ipfs_pkg.sv
// ----------------------------------------------------------------------------
// Index pool free stack package
// Shared widths, command codes, default sizes and the result word type.
// ----------------------------------------------------------------------------
`default_nettype none

package ipfs_pkg;

   localparam int IDX_W         = 10;
   localparam int COUNT_W       = 7;
   localparam int USE_W         = 11;
   localparam int CAPACITY_DEF  = 1024;
   localparam int MAX_BATCH_DEF = 64;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   typedef struct packed {
      logic [IDX_W-1:0] slot_index;
      logic             granted;
      logic             last;
      logic [USE_W-1:0] in_use_count;
      logic             overflow;
   } rsp_word_type;

endpackage

`default_nettype wire

FILE: rtl/index_pool_free_stack_core.sv
// ----------------------------------------------------------------------------
// Index pool free stack core
// Hands out slot indices from a last-in first-out stack of free indices and
// takes returned indices back onto it.
//
//   Channel | Direction | Handshake          | Word
//   req_    | in        | req_valid/stall    | command, request_count, index
//   rsp_    | out       | rsp_valid/stall    | slot index, flags, in-use count
//
// A free or an allocate that grants nothing gives one word. An allocate
// granting n indices issues n stack memory reads, one per cycle while the
// response queue has room; each word passes the memory read register and then the queue.
// The stack memory is never cleared: a low watermark of the stack depth
// tells which entries still hold their reset value, so the block is ready
// right after reset. A stall on the response side fills the two-word queue
// and then holds off further pops and new requests.
// ----------------------------------------------------------------------------
`default_nettype none

module index_pool_free_stack_core
   import ipfs_pkg::*;
#(
   parameter int CAPACITY  = CAPACITY_DEF,
   parameter int MAX_BATCH = MAX_BATCH_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_command,
   input  wire logic [COUNT_W-1:0] req_request_count,
   input  wire logic [IDX_W-1:0]   req_returned_index,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic      [IDX_W-1:0]   rsp_slot_index,
   output logic                    rsp_granted,
   output logic                    rsp_last,
   output logic      [USE_W-1:0]   rsp_in_use_count,
   output logic                    rsp_overflow
);

   localparam int DW = $clog2(CAPACITY + 1);
   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam logic [DW-1:0]      CAP_D   = DW'(CAPACITY);
   localparam logic [COUNT_W-1:0] BATCH_C = COUNT_W'(MAX_BATCH);

   typedef struct packed {
      logic             from_mem;
      logic [IDX_W-1:0] slot_index;
      logic             granted;
      logic             last;
      logic [USE_W-1:0] in_use_count;
      logic             overflow;
   } pend_word_type;

   logic               busy_ff;
   logic               busy_in;
   logic [COUNT_W-1:0] remain_ff;
   logic [COUNT_W-1:0] remain_in;
   logic [DW-1:0]      depth_ff;
   logic [DW-1:0]      depth_in;
   logic [DW-1:0]      low_ff;
   logic [DW-1:0]      low_in;
   logic [DW-1:0]      used_ff;
   logic [DW-1:0]      used_in;
   logic               pend_valid_ff;
   logic               pend_valid_in;
   pend_word_type      pend_ff;
   pend_word_type      pend_in;

   logic               deq;
   logic               room;
   logic               accept;
   logic               pop_go;
   logic               pop_last;
   logic [COUNT_W-1:0] want;
   logic [DW-1:0]      top_addr;
   logic               mem_we;
   logic               mem_re;
   logic [IDX_W-1:0]   mem_rd_data;
   logic [1:0]         q_count;
   rsp_word_type       push_word;
   rsp_word_type       out_word;

   always_comb begin
      deq      = rsp_valid & ~rsp_stall;
      room     = ({1'b0, q_count} + {2'b00, pend_valid_ff}) <= (3'd1 + {2'b00, deq});
      req_stall = busy_ff | ~room;
      accept   = req_valid & ~req_stall;
      want     = (req_request_count > BATCH_C) ? BATCH_C : req_request_count;
      top_addr = depth_ff - DW'(1);

      busy_in       = busy_ff;
      remain_in     = remain_ff;
      depth_in      = depth_ff;
      low_in        = low_ff;
      used_in       = used_ff;
      pend_valid_in = 1'b0;
      pend_in       = '0;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      pop_go        = 1'b0;
      pop_last      = 1'b0;

      if (accept) begin
         if (req_command == CMD_FREE) begin
            pend_valid_in = 1'b1;
            pend_in.last  = 1'b1;
            if (depth_ff >= CAP_D) begin
               pend_in.overflow     = 1'b1;
               pend_in.in_use_count = USE_W'(used_ff);
            end else begin
               mem_we   = 1'b1;
               depth_in = depth_ff + DW'(1);
               if (used_ff != '0) begin
                  used_in = used_ff - DW'(1);
               end
               pend_in.in_use_count = USE_W'(used_in);
            end
         end else if ((want == '0) || (depth_ff == '0)) begin
            pend_valid_in        = 1'b1;
            pend_in.last         = 1'b1;
            pend_in.in_use_count = USE_W'(used_ff);
         end else begin
            pop_go    = 1'b1;
            pop_last  = (want == COUNT_W'(1)) || (depth_ff == DW'(1));
            busy_in   = ~pop_last;
            remain_in = want - COUNT_W'(1);
         end
      end else if (busy_ff && room) begin
         pop_go    = 1'b1;
         pop_last  = (remain_ff == COUNT_W'(1)) || (depth_ff == DW'(1));
         busy_in   = ~pop_last;
         remain_in = remain_ff - COUNT_W'(1);
      end

      if (pop_go) begin
         mem_re   = 1'b1;
         depth_in = top_addr;
         used_in  = used_ff + DW'(1);
         if (top_addr < low_ff) begin
            low_in = top_addr;
         end
         pend_valid_in        = 1'b1;
         pend_in.from_mem     = (top_addr >= low_ff);
         pend_in.slot_index   = IDX_W'(top_addr);
         pend_in.granted      = 1'b1;
         pend_in.last         = pop_last;
         pend_in.in_use_count = USE_W'(used_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         remain_ff     <= '0;
         depth_ff      <= CAP_D;
         low_ff        <= CAP_D;
         used_ff       <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         remain_ff     <= remain_in;
         depth_ff      <= depth_in;
         low_ff        <= low_in;
         used_ff       <= used_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
   end

   ipfs_stack_mem #(
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (AW'(depth_ff)),
      .wr_data (req_returned_index),
      .rd_en   (mem_re),
      .rd_addr (AW'(top_addr)),
      .rd_data (mem_rd_data)
   );

   always_comb begin
      push_word.slot_index   = pend_ff.from_mem ? mem_rd_data : pend_ff.slot_index;
      push_word.granted      = pend_ff.granted;
      push_word.last         = pend_ff.last;
      push_word.in_use_count = pend_ff.in_use_count;
      push_word.overflow     = pend_ff.overflow;
   end

   ipfs_rsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (pend_valid_ff),
      .push_word  (push_word),
      .pop        (deq),
      .out_valid  (rsp_valid),
      .out_word   (out_word),
      .count      (q_count)
   );

   assign rsp_slot_index   = out_word.slot_index;
   assign rsp_granted      = out_word.granted;
   assign rsp_last         = out_word.last;
   assign rsp_in_use_count = out_word.in_use_count;
   assign rsp_overflow     = out_word.overflow;

endmodule

`default_nettype wire

FILE: rtl/ipfs_stack_mem.sv
// ----------------------------------------------------------------------------
// Index pool free stack memory
// Single-port-write, single-port-read synchronous memory holding the stack
// entries, with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ipfs_stack_mem
   import ipfs_pkg::*;
#(
   parameter int DEPTH = CAPACITY_DEF,
   parameter int AW    = 10
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [IDX_W-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [IDX_W-1:0] rd_data
);

   logic [IDX_W-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: rtl/ipfs_rsp_queue.sv
// ----------------------------------------------------------------------------
// Index pool free stack response queue
// Two-word queue in front of the response channel. It decouples the stack
// pipeline from stalls on the response side.
// ----------------------------------------------------------------------------
`default_nettype none

module ipfs_rsp_queue
   import ipfs_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push_valid,
   input  wire rsp_word_type push_word,
   input  wire logic         pop,
   output logic              out_valid,
   output rsp_word_type      out_word,
   output logic [1:0]        count
);

   rsp_word_type entry_ff [2];
   logic         wr_ptr_ff;
   logic         wr_ptr_in;
   logic         rd_ptr_ff;
   logic         rd_ptr_in;
   logic [1:0]   count_ff;
   logic [1:0]   count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push_valid;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push_valid} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_word;
      end
   end

   assign out_valid = (count_ff != 2'd0);
   assign out_word  = entry_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

`default_nettype wire

FILE: rtl/ipfs_checker.sv
// ----------------------------------------------------------------------------
// Index pool free stack checker
// Port-level checks on the response words, bound to the core.
// ----------------------------------------------------------------------------
`default_nettype none

module ipfs_checker
   import ipfs_pkg::*;
(
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire logic [IDX_W-1:0] rsp_slot_index,
   input wire logic             rsp_granted,
   input wire logic             rsp_last,
   input wire logic [USE_W-1:0] rsp_in_use_count,
   input wire logic             rsp_overflow
);

   // A granted word never reports a dropped free.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_granted |-> !rsp_overflow)
      else $error("granted word with overflow set");

   // A word that grants nothing carries a zero index and closes its request.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_granted |-> rsp_last && (rsp_slot_index == '0))
      else $error("non-granted word with index or without last");

   // Within a batch the in-use count rises by one from word to word.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_granted && !rsp_last ##1 rsp_valid
      |-> rsp_granted && (rsp_in_use_count == $past(rsp_in_use_count) + USE_W'(1)))
      else $error("batch word sequence broken");

   // A stalled response word holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_slot_index)
         && $stable(rsp_in_use_count) && $stable(rsp_last))
      else $error("stalled response word changed");

endmodule

bind index_pool_free_stack_core ipfs_checker u_ipfs_checker (.*);

`default_nettype wire
